// ----- sv/esf_pkg.sv -----
// ----------------------------------------------------------------------------
// esf_pkg: shared types and constants of the escape stuffing framer
// Byte constants, mode codes and the frame descriptor that travels from the
// classifier to the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package esf_pkg;

  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] ESC_RESET = 8'd27;

  // most framed bytes one message byte can cause
  localparam int MAX_BYTES = 4;
  localparam int IDX_W     = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // default depth of the descriptor queue
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_TEXT    = 2'd0,
    MODE_BIN     = 2'd1,
    MODE_BIN_LEN = 2'd2
  } mode_e;

  typedef struct packed {
    logic [CNT_W-1:0]               count;
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } desc_t;

endpackage

`default_nettype wire

// ----- sv/esf_front.sv -----
// ----------------------------------------------------------------------------
// esf_front: item classifier
// Holds the escape register, expands each accepted item into a descriptor of
// up to four framed bytes and pushes it to the queue. Empty results are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module esf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           mode_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 is_first_i,
  input  logic                 is_last_i,
  input  logic                 drop_zeros_i,
  input  logic                 append_crlf_i,
  input  logic [7:0]           message_length_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output esf_pkg::desc_t       q_desc_o
);
  import esf_pkg::*;

  logic [7:0]      esc_q;
  logic [CNT_W-1:0] cnt;
  logic [MAX_BYTES-1:0][7:0] bytes;
  logic            keep;
  logic            crlf_en;
  logic            is_esc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= ESC_RESET;
    end else if (cfg_we_i) begin
      esc_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    cnt     = '0;
    bytes   = '0;
    keep    = (data_byte_i != 8'd0) || !drop_zeros_i;
    crlf_en = is_last_i && append_crlf_i;
    is_esc  = (data_byte_i == esc_q);
    case (mode_e'(mode_i))
      MODE_TEXT: begin
        if (keep) begin
          bytes[0] = data_byte_i;
          cnt      = CNT_W'(1);
        end
        if (crlf_en) begin
          bytes[cnt[IDX_W-1:0]]          = CR_BYTE;
          bytes[cnt[IDX_W-1:0] + 1'b1]   = LF_BYTE;
          cnt                            = cnt + CNT_W'(2);
        end
      end
      MODE_BIN, MODE_BIN_LEN: begin
        if (is_first_i) begin
          bytes[0] = esc_q;
          cnt      = CNT_W'(1);
          if (mode_e'(mode_i) == MODE_BIN_LEN) begin
            bytes[1] = message_length_i;
            cnt      = CNT_W'(2);
          end
        end
        bytes[cnt[IDX_W-1:0]] = data_byte_i;
        cnt                   = cnt + CNT_W'(1);
        // double a data byte that collides with the escape
        if (is_esc) begin
          bytes[cnt[IDX_W-1:0]] = data_byte_i;
          cnt                   = cnt + CNT_W'(1);
        end
      end
      default: begin
        cnt = '0;
      end
    endcase
  end

  assign in_stall_o     = q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i && (cnt != '0);
  assign q_desc_o.count = cnt;
  assign q_desc_o.bytes = bytes;

endmodule

`default_nettype wire

// ----- sv/esf_queue.sv -----
// ----------------------------------------------------------------------------
// esf_queue: descriptor queue
// Short FIFO between classifier and sequencer so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module esf_queue #(
  parameter int DEPTH = esf_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  esf_pkg::desc_t  push_desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output esf_pkg::desc_t  head_o,
  output logic            empty_o
);
  import esf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  desc_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (level_q == LVL_W'(DEPTH));
  assign empty_o = (level_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      level_d = level_q + 1'b1;
    end else if (do_pop && !do_push) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/esf_back.sv -----
// ----------------------------------------------------------------------------
// esf_back: byte sequencer
// Walks the head descriptor one byte per cycle, while the output is not stalled,
// into the output register and pops it after its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module esf_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  esf_pkg::desc_t  head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_last_o
);
  import esf_pkg::*;

  logic [IDX_W-1:0] idx_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             out_last_q;
  logic             advance;
  logic             take;
  logic             final_byte;

  assign advance    = !out_valid_q || !out_stall_i;
  assign take       = advance && !empty_i;
  assign final_byte = ({1'b0, idx_q} + CNT_W'(1)) == head_i.count;
  assign pop_o      = take && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= !empty_i;
      if (take) begin
        idx_q <= final_byte ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_byte_q <= head_i.bytes[idx_q];
      out_last_q <= final_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- sv/escape_stuffing_tx_framer.sv -----
// Path: an accepted item is written into the queue, and the output register then
//   loads its first framed byte from the queue head once the output is not stalled.
// Throughput: one item a cycle while the queue has room; output runs at one
//   byte a cycle while not stalled, each pushed item giving 1 to 4 framed bytes.
// Reset: asynchronous, clears queue and output valid, escape register to 27.
// ----------------------------------------------------------------------------
// escape_stuffing_tx_framer: escape byte stuffing transmit framer
// Classifier front, descriptor queue, byte sequencer back.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_stuffing_tx_framer #(
  parameter int QUEUE_DEPTH = esf_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  input  logic        is_first_i,
  input  logic        is_last_i,
  input  logic        drop_zeros_i,
  input  logic        append_crlf_i,
  input  logic [7:0]  message_length_i,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o
);
  import esf_pkg::*;

  desc_t push_desc;
  desc_t head_desc;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;

  esf_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .is_first_i       (is_first_i),
    .is_last_i        (is_last_i),
    .drop_zeros_i     (drop_zeros_i),
    .append_crlf_i    (append_crlf_i),
    .message_length_i (message_length_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_desc_o         (push_desc)
  );

  esf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (head_desc),
    .empty_o     (q_empty)
  );

  esf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_desc),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

// ----- sv/esf_checker.sv -----
// ----------------------------------------------------------------------------
// esf_checker: port-level checks of the framer
// Output hold under stall, reset state, back-to-back bytes within an item and
// prompt output for binary-mode items.
// ----------------------------------------------------------------------------
`default_nettype none

module esf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_o,
  input  logic        out_last_o
);
  import esf_pkg::*;

  logic in_take;
  assign in_take = in_valid_i && !in_stall_o;

  // hold a stalled output item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("stalled output item changed");

  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // bytes of one item follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=> out_valid_o)
    else $error("gap inside one item's framed bytes");

  a_bin_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && !out_valid_o && (mode_i == MODE_BIN || mode_i == MODE_BIN_LEN)
    |-> ##2 out_valid_o)
    else $error("binary item produced no output");

endmodule

bind escape_stuffing_tx_framer esf_checker u_esf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .mode_i      (mode_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the escape stuffing transmit framer
// Drives message bytes through the valid/stall input channel, predicts the
// framed byte stream per accepted item and checks each output byte and its
// last mark in order. Covers text, binary and length modes, undefined modes,
// several escape values, random idling on both sides and long back pressure.
// ----------------------------------------------------------------------------
module tb;
  import esf_pkg::*;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam int CLK_HALF_NS  = 6;
  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int TIMEOUT_NS   = 4_000_000;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } framed_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall_o;
  logic [1:0] mode = MODE_TEXT;
  logic [7:0] data_byte = 8'h00;
  logic       is_first = 1'b0;
  logic       is_last = 1'b0;
  logic       drop_zeros = 1'b0;
  logic       append_crlf = 1'b0;
  logic [7:0] message_length = 8'h00;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic       out_valid_o;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  framed_t    framed_q[$];
  framed_t    got_framed;
  logic [7:0] esc_model = ESC_RESET;
  logic [7:0] cur_escape = ESC_RESET;
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  logic       hold_go = 1'b0;
  logic       hold_seen = 1'b0;
  int         hold_cnt = 0;

  escape_stuffing_tx_framer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode),
    .data_byte_i      (data_byte),
    .is_first_i       (is_first),
    .is_last_i        (is_last),
    .drop_zeros_i     (drop_zeros),
    .append_crlf_i    (append_crlf),
    .message_length_i (message_length),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte_o),
    .out_last_o       (out_last_o)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // Framed bytes that one message byte causes, appended to the expected store.
  function automatic void frame_item(logic [1:0] m, logic [7:0] d, logic f, logic l,
                                     logic dz, logic cr, logic [7:0] len);
    framed_t fb[$];
    case (m)
      MODE_TEXT: begin
        if (d != 8'h00 || !dz) fb.push_back({d, 1'b0});
        if (l && cr) begin
          fb.push_back({CR_BYTE, 1'b0});
          fb.push_back({LF_BYTE, 1'b0});
        end
      end
      MODE_BIN, MODE_BIN_LEN: begin
        if (f) begin
          fb.push_back({esc_model, 1'b0});
          if (m == MODE_BIN_LEN) fb.push_back({len, 1'b0});
        end
        fb.push_back({d, 1'b0});
        if (d == esc_model) fb.push_back({d, 1'b0});
      end
      default: ;
    endcase
    if (fb.size() != 0) fb[fb.size()-1].last = 1'b1;
    foreach (fb[i]) framed_q.push_back(fb[i]);
  endfunction

  // Check output bytes, then predict accepted items, then track the register.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) begin
        if (framed_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, out_byte_o, out_last_o);
        end else begin
          got_framed = framed_q.pop_front();
          if (out_byte_o !== got_framed.b) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, got_framed.b, out_byte_o);
          end
          if (out_last_o !== got_framed.last) begin
            errors++;
            $display("%0t: out_last mismatch: expected %0b, actual %0b",
                     $time, got_framed.last, out_last_o);
          end
        end
      end
      if (in_valid && !in_stall_o)
        frame_item(mode, data_byte, is_first, is_last, drop_zeros, append_crlf,
                   message_length);
      if (cfg_we) esc_model = cfg_wdata;
    end
  end

  // Receiver: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [1:0] m, input logic [7:0] d, input logic f,
                           input logic l, input logic dz, input logic cr,
                           input logic [7:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= m;
    data_byte      <= d;
    is_first       <= f;
    is_last        <= l;
    drop_zeros     <= dz;
    append_crlf    <= cr;
    message_length <= len;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  // Stop offering items and wait until every framed byte is out.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (framed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_escape(input logic [7:0] v);
    wait_drain();
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    cur_escape = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Bias data toward the escape value and zero.
  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(7);
    if (r < 2) return cur_escape;
    if (r == 2) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message(input logic [1:0] m, input int n);
    logic [7:0] len;
    len = ($urandom_range(1)) ? 8'(n) : 8'($urandom_range(255));
    for (int i = 0; i < n; i++)
      send_byte(m, pick_data(), i == 0, i == n - 1, 1'($urandom_range(1)),
                1'($urandom_range(1)), len);
  endtask

  task automatic test_text_mode();
    send_byte(MODE_TEXT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);  // dropped zero
    send_byte(MODE_TEXT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 8'h00);
    send_byte(MODE_TEXT, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 8'h55);
    send_byte(MODE_TEXT, 8'h41, 1'b0, 1'b1, 1'b0, 1'b1, 8'hFF);
    send_byte(MODE_TEXT, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00);  // zero gone, CR LF kept
    send_byte(MODE_TEXT, 8'h00, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
    wait_drain();
  endtask

  task automatic test_binary_mode();
    send_byte(MODE_BIN, ESC_RESET, 1'b1, 1'b0, 1'b0, 1'b0, 8'h10);
    send_byte(MODE_BIN, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    send_byte(MODE_BIN, ESC_RESET, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
    send_byte(MODE_BIN, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1, 8'h77);
    wait_drain();
  endtask

  task automatic test_length_mode();
    send_byte(MODE_BIN_LEN, ESC_RESET, 1'b1, 1'b0, 1'b0, 1'b0, 8'hFF);
    send_byte(MODE_BIN_LEN, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00);
    send_byte(MODE_BIN_LEN, ESC_RESET, 1'b0, 1'b1, 1'b0, 1'b0, 8'hAA);
    wait_drain();
  endtask

  task automatic test_undefined_mode();
    send_byte(MODE_UNDEF, ESC_RESET, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    send_byte(MODE_UNDEF, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    send_byte(MODE_TEXT, 8'h5A, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
    wait_drain();
  endtask

  task automatic test_escape_extremes();
    set_escape(8'h00);
    send_byte(MODE_BIN, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    send_byte(MODE_BIN_LEN, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
    send_byte(MODE_BIN, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    set_escape(8'hFF);
    send_byte(MODE_BIN_LEN, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 8'hFF);
    send_byte(MODE_TEXT, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    wait_drain();
  endtask

  task automatic random_phase(input int s_pct, input int r_pct, input logic [7:0] esc,
                              input int n_items, input bit with_pause);
    int sent;
    int n;
    sent = 0;
    set_escape(esc);
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    while (sent < n_items) begin
      if (with_pause && sent >= n_items / 2) begin
        // hold the sender until the block has emptied out
        wait_drain();
        with_pause = 1'b0;
      end
      if ($urandom_range(99) < 85) begin
        n = $urandom_range(1, 6);
        send_message(2'($urandom_range(2)), n);
        sent += n;
      end else begin
        send_byte(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  8'($urandom_range(255)));
        sent++;
      end
    end
    wait_drain();
  endtask

  task automatic test_random_frames();
    random_phase(24, 66, 8'($urandom_range(255)), 100, 1'b0);
    random_phase(66, 24, 8'hFF, 100, 1'b1);
    random_phase(0, 0, CR_BYTE, 50, 1'b0);
    random_phase(0, 0, 8'h00, 50, 1'b0);
  endtask

  task automatic test_backpressure();
    set_escape(ESC_RESET);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_go <= ~hold_go;
    // keep offering while the output is held so the queue fills and stalls input
    for (int i = 0; i < 24; i++)
      send_byte(MODE_BIN_LEN, pick_data(), (i % 6) == 0, 1'b0, 1'b0, 1'b0,
                8'($urandom_range(255)));
    wait_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_text_mode();
    test_binary_mode();
    test_length_mode();
    test_undefined_mode();
    test_escape_extremes();
    test_random_frames();
    test_backpressure();
    wait_drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
